[hdl/ffba_pkg.sv]
package ffba_pkg;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic CFG_HEAP_BASE  = 1'b0;
    localparam logic CFG_HEAP_BYTES = 1'b1;

    localparam logic [2:0] ST_REUSED     = 3'd0;
    localparam logic [2:0] ST_APPENDED   = 3'd1;
    localparam logic [2:0] ST_TABLE_FULL = 3'd2;
    localparam logic [2:0] ST_NO_SPACE   = 3'd3;
    localparam logic [2:0] ST_FREED      = 3'd4;
    localparam logic [2:0] ST_UNKNOWN    = 3'd5;

    typedef struct packed {
        logic        op;
        logic [63:0] amount_or_address;
    } t_request;

    typedef struct packed {
        logic [63:0] data_address;
        logic [2:0]  status;
    } t_result;

endpackage

[hdl/first_fit_block_allocator.sv]
// Channel    Direction  Transfer when            Payload
// request    in         start && !busy           i_req (t_request)
// result     out        o_valid (one cycle)      o_result (t_result)
// config     in         i_cfg_we                 i_cfg_idx, i_cfg_wdata
//
// One request at a time: the table memory is read one entry per cycle, and
// the registered read port sets the pace; the scan walks the table entries in
// order and strobes the result at the first hit or after the last entry.
// busy stays high from the accepting edge until the result cycle.
// Synchronous active-low reset clears the state, table count, bump pointer,
// pend and valid flags and heap config; table entries are only read below
// the count. The receiver cannot stall: o_valid lasts exactly one cycle.
module first_fit_block_allocator
    import ffba_pkg::*;
#(
    parameter int MAX_BLOCKS   = 64,
    parameter int HEADER_BYTES = 24,
    parameter int OFFSET_BITS  = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_request    i_req,
    output logic        o_valid,
    output t_result     o_result,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [63:0] i_cfg_wdata
);

    localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int OW = (OFFSET_BITS < 32) ? OFFSET_BITS : 32;
    localparam logic [63:0] HDR = 64'(HEADER_BYTES);
    localparam logic [31:0] LIM_MASK = (OFFSET_BITS >= 32) ? 32'hFFFF_FFFF
                                       : 32'((64'd1 << OFFSET_BITS) - 64'd1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    typedef struct packed {
        logic [OW-1:0] offset;
        logic [OW-1:0] size;
        logic          used;
    } t_block;

    t_block        mem [MAX_BLOCKS];
    t_block        r_rd;

    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx, n_idx;
    logic [AW-1:0] r_pidx, n_pidx;
    logic          r_pend, n_pend;
    logic          r_seen, n_seen;
    logic          r_op, n_op;
    logic [63:0]   r_arg, n_arg;
    logic [OW-1:0] r_bump, n_bump;
    logic [63:0]   r_base;
    logic [31:0]   r_bytes;
    logic          r_valid, n_valid;
    t_result       r_out, n_out;

    logic          mem_we;
    logic [AW-1:0] mem_wa;
    t_block        mem_wd;
    logic [AW-1:0] mem_ra;

    logic          match;
    logic          hit;
    logic [31:0]   limit;
    logic          too_big;
    logic [33:0]   total;

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_out;

    assign match = (r_op == OP_FREE)
                   ? (64'(r_rd.offset) == r_arg)
                   : (!r_rd.used && (64'(r_rd.size) >= r_arg));
    assign hit   = r_pend && match && ((r_op == OP_ALLOC) || r_rd.used);

    assign limit   = (r_bytes < LIM_MASK) ? r_bytes : LIM_MASK;
    assign too_big = (|r_arg[63:32]) || (r_arg[31:0] > limit) || (32'(r_bump) > limit);
    assign total   = 34'(r_bump) + 34'(HEADER_BYTES) + 34'(r_arg[31:0]);

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_idx   = r_idx;
        n_pidx  = r_pidx;
        n_pend  = 1'b0;
        n_seen  = r_seen;
        n_op    = r_op;
        n_arg   = r_arg;
        n_bump  = r_bump;
        n_valid = 1'b0;
        n_out   = r_out;
        mem_we  = 1'b0;
        mem_wa  = r_pidx;
        mem_wd  = r_rd;
        mem_ra  = r_idx[AW-1:0];
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op   = i_req.op;
                    n_arg  = (i_req.op == OP_FREE)
                             ? (i_req.amount_or_address - r_base - HDR)
                             : i_req.amount_or_address;
                    n_idx  = '0;
                    n_seen = 1'b0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_pend && match && (r_op == OP_FREE) && !r_rd.used) begin
                    n_seen = 1'b1;
                end
                if (hit) begin
                    mem_we = 1'b1;
                    mem_wd.used = (r_op == OP_ALLOC);
                    n_valid = 1'b1;
                    if (r_op == OP_ALLOC) begin
                        n_out.data_address = r_base + 64'(r_rd.offset) + HDR;
                        n_out.status = ST_REUSED;
                    end else begin
                        n_out.data_address = '0;
                        n_out.status = ST_FREED;
                    end
                    n_state = S_IDLE;
                end else if (r_idx < r_count) begin
                    n_pend = 1'b1;
                    n_pidx = r_idx[AW-1:0];
                    n_idx  = r_idx + 1'b1;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                n_valid = 1'b1;
                n_out.data_address = '0;
                n_state = S_IDLE;
                if (r_op == OP_FREE) begin
                    n_out.status = r_seen ? ST_FREED : ST_UNKNOWN;
                end else if (r_count == CW'(MAX_BLOCKS)) begin
                    n_out.status = ST_TABLE_FULL;
                end else if (too_big || (total > 34'(limit))) begin
                    n_out.status = ST_NO_SPACE;
                end else begin
                    mem_we        = 1'b1;
                    mem_wa        = r_count[AW-1:0];
                    mem_wd.offset = r_bump;
                    mem_wd.size   = r_arg[OW-1:0];
                    mem_wd.used   = 1'b1;
                    n_count       = r_count + 1'b1;
                    n_bump        = total[OW-1:0];
                    n_out.data_address = r_base + 64'(r_bump) + HDR;
                    n_out.status  = ST_APPENDED;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd <= mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_bump  <= '0;
            r_pend  <= 1'b0;
            r_valid <= 1'b0;
            r_base  <= '0;
            r_bytes <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_bump  <= n_bump;
            r_pend  <= n_pend;
            r_valid <= n_valid;
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_HEAP_BASE) begin
                    r_base <= i_cfg_wdata;
                end else begin
                    r_bytes <= i_cfg_wdata[31:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_pidx <= n_pidx;
        r_seen <= n_seen;
        r_op   <= n_op;
        r_arg  <= n_arg;
        r_out  <= n_out;
    end

endmodule

[hdl/ffba_chk.sv]
module ffba_chk
    import ffba_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     start,
    input logic     busy,
    input logic     o_valid,
    input t_result  o_result
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted request did not raise busy");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobed while busy");

    a_fell_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid)
        else $error("busy dropped without a result");

    a_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !(o_result.status == ST_REUSED || o_result.status == ST_APPENDED)
        |-> o_result.data_address == 64'd0)
        else $error("address given without a grant");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_result.status <= ST_UNKNOWN)
        else $error("status out of range");

endmodule

bind first_fit_block_allocator ffba_chk u_ffba_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_valid  (o_valid),
    .o_result (o_result)
);

[sim/first_fit_block_allocator_tb.sv]
module first_fit_block_allocator_tb;

    import ffba_pkg::*;

    localparam int N_BLOCKS     = 64;
    localparam int HDR          = 24;
    localparam int OFS_BITS     = 32;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = N_BLOCKS + 16;

    typedef enum logic {
        ROW_REQ,
        ROW_CFG
    } t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        logic        op;
        logic [63:0] val;
        logic [31:0] bytes;
        bit          has_want;
        t_result     want;
    } t_dir_row;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        start       = 1'b0;
    t_request    i_req       = '0;
    logic        i_cfg_we    = 1'b0;
    logic        i_cfg_idx   = CFG_HEAP_BASE;
    logic [63:0] i_cfg_wdata = '0;
    logic        busy;
    logic        o_valid;
    t_result     o_result;

    logic [31:0] blk_off  [N_BLOCKS];
    logic [31:0] blk_size [N_BLOCKS];
    logic        blk_used [N_BLOCKS];
    int unsigned blk_count  = 0;
    logic [63:0] bump_off   = '0;
    logic [63:0] base_addr  = '0;
    logic [31:0] heap_bytes = '0;

    t_result awaited_grants [$];
    t_result grant_due;
    int      mismatch_count = 0;
    int      idle_cycles    = 0;
    int      burst_left     = 1;

    first_fit_block_allocator #(
        .MAX_BLOCKS  (N_BLOCKS),
        .HEADER_BYTES(HDR),
        .OFFSET_BITS (OFS_BITS)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .o_valid    (o_valid),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic [63:0] block_addr(int unsigned idx);
        return base_addr + {32'd0, blk_off[idx]} + 64'(HDR);
    endfunction

    function automatic t_result compute_grant(t_request req);
        t_result     res;
        logic [63:0] limit;
        logic [63:0] mask;
        logic [63:0] total;
        bit          done;
        bit          seen;
        res.data_address = '0;
        res.status       = ST_UNKNOWN;
        done             = 1'b0;
        seen             = 1'b0;
        if (req.op == OP_ALLOC) begin
            for (int unsigned i = 0; i < blk_count && !done; i++) begin
                if (!blk_used[i] && {32'd0, blk_size[i]} >= req.amount_or_address) begin
                    blk_used[i]      = 1'b1;
                    res.data_address = block_addr(i);
                    res.status       = ST_REUSED;
                    done             = 1'b1;
                end
            end
            if (!done) begin
                mask  = (64'd1 << OFS_BITS) - 64'd1;
                limit = ({32'd0, heap_bytes} < mask) ? {32'd0, heap_bytes} : mask;
                total = bump_off + 64'(HDR) + req.amount_or_address;
                if (blk_count >= N_BLOCKS) begin
                    res.status = ST_TABLE_FULL;
                end else if (req.amount_or_address > limit || bump_off > limit
                             || total > limit) begin
                    res.status = ST_NO_SPACE;
                end else begin
                    blk_off[blk_count]  = bump_off[31:0];
                    blk_size[blk_count] = req.amount_or_address[31:0];
                    blk_used[blk_count] = 1'b1;
                    res.data_address    = block_addr(blk_count);
                    res.status          = ST_APPENDED;
                    blk_count           = blk_count + 1;
                    bump_off            = total;
                end
            end
        end else begin
            for (int unsigned i = 0; i < blk_count && !done; i++) begin
                if (block_addr(i) == req.amount_or_address) begin
                    if (blk_used[i]) begin
                        blk_used[i] = 1'b0;
                        res.status  = ST_FREED;
                        done        = 1'b1;
                    end else begin
                        seen = 1'b1;
                    end
                end
            end
            if (!done) begin
                res.status = seen ? ST_FREED : ST_UNKNOWN;
            end
        end
        return res;
    endfunction

    function automatic t_request random_request(int alloc_pct, bit wide_amounts);
        t_request    r;
        int          sel;
        int unsigned idx;
        sel = $urandom_range(0, 99);
        if (sel < alloc_pct) begin
            r.op = OP_ALLOC;
            sel  = $urandom_range(0, 99);
            if (sel < 75) begin
                r.amount_or_address = 64'($urandom_range(0, 256));
            end else if (sel < 88) begin
                r.amount_or_address = 64'($urandom_range(257, 65535));
            end else if (sel < 95 && wide_amounts) begin
                r.amount_or_address = {32'd0, $urandom};
            end else begin
                r.amount_or_address = {$urandom, $urandom};
            end
        end else begin
            r.op = OP_FREE;
            sel  = $urandom_range(0, 99);
            idx  = (blk_count > 0) ? $urandom_range(0, blk_count - 1) : 0;
            if (blk_count > 0 && sel < 80) begin
                r.amount_or_address = block_addr(idx);
            end else if (blk_count > 0 && sel < 92) begin
                r.amount_or_address = block_addr(idx) ^ 64'($urandom_range(1, 7));
            end else begin
                r.amount_or_address = {$urandom, $urandom};
            end
        end
        return r;
    endfunction

    function automatic t_dir_row row_req(logic op, logic [63:0] val);
        t_dir_row row;
        row          = '0;
        row.kind     = ROW_REQ;
        row.op       = op;
        row.val      = val;
        return row;
    endfunction

    function automatic t_dir_row row_chk(logic op, logic [63:0] val, logic [63:0] addr,
                                         logic [2:0] status);
        t_dir_row row;
        row                   = row_req(op, val);
        row.has_want          = 1'b1;
        row.want.data_address = addr;
        row.want.status       = status;
        return row;
    endfunction

    function automatic t_dir_row row_cfg(logic [63:0] base, logic [31:0] bytes);
        t_dir_row row;
        row       = '0;
        row.kind  = ROW_CFG;
        row.val   = base;
        row.bytes = bytes;
        return row;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t: %s mismatch: got %h, want %h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic pace();
        if (burst_left > 0) begin
            burst_left--;
        end
        if (burst_left == 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat ($urandom_range(0, 10)) @(negedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
    endtask

    task automatic send_request(t_request req, bit has_want, t_result want);
        t_result predicted;
        @(negedge i_clk);
        start <= 1'b1;
        i_req <= req;
        do @(posedge i_clk); while (busy);
        predicted = compute_grant(req);
        awaited_grants.push_back(has_want ? want : predicted);
        pace();
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        start <= 1'b0;
        while (awaited_grants.size() != 0) @(posedge i_clk);
        while (busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_heap(logic [63:0] base, logic [31:0] bytes);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_HEAP_BASE;
        i_cfg_wdata <= base;
        @(posedge i_clk);
        base_addr = base;
        @(negedge i_clk);
        i_cfg_idx   <= CFG_HEAP_BYTES;
        i_cfg_wdata <= {32'd0, bytes};
        @(posedge i_clk);
        heap_bytes = bytes;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (awaited_grants.size() == 0) begin
                report_mismatch("unexpected transfer", o_result.data_address, '0);
            end else begin
                grant_due = awaited_grants.pop_front();
                if (o_result.data_address !== grant_due.data_address) begin
                    report_mismatch("data_address", o_result.data_address,
                                    grant_due.data_address);
                end
                if (o_result.status !== grant_due.status) begin
                    report_mismatch("status", 64'(o_result.status), 64'(grant_due.status));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid || i_cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        t_dir_row    rows [$];
        t_request    req;
        logic [63:0] room;
        int          alloc_pct;
        rows.push_back(row_chk(OP_ALLOC, 64'd0, 64'd0, ST_NO_SPACE));
        rows.push_back(row_chk(OP_FREE, 64'd0, 64'd0, ST_UNKNOWN));
        rows.push_back(row_cfg(64'hFFFF_FFFF_FFFF_FF00, 32'hFFFF_FFFF));
        rows.push_back(row_chk(OP_ALLOC, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, ST_NO_SPACE));
        rows.push_back(row_chk(OP_ALLOC, 64'h0000_0000_FFFF_FFFF, 64'd0, ST_NO_SPACE));
        rows.push_back(row_req(OP_ALLOC, 64'd0));
        rows.push_back(row_req(OP_ALLOC, 64'd100));
        rows.push_back(row_req(OP_ALLOC, 64'd5));
        rows.push_back(row_req(OP_ALLOC, 64'd300));
        rows.push_back(row_req(OP_ALLOC, 64'd8));
        rows.push_back(row_chk(OP_FREE, 64'hFFFF_FFFF_FFFF_FF30, 64'd0, ST_FREED));
        rows.push_back(row_chk(OP_FREE, 64'hFFFF_FFFF_FFFF_FF30, 64'd0, ST_FREED));
        rows.push_back(row_chk(OP_FREE, 64'hFFFF_FFFF_FFFF_FF31, 64'd0, ST_UNKNOWN));
        rows.push_back(row_req(OP_ALLOC, 64'd101));
        rows.push_back(row_chk(OP_ALLOC, 64'd100, 64'hFFFF_FFFF_FFFF_FF30, ST_REUSED));
        rows.push_back(row_req(OP_FREE, 64'hFFFF_FFFF_FFFF_FF18));
        rows.push_back(row_req(OP_ALLOC, 64'd1));
        rows.push_back(row_chk(OP_ALLOC, 64'd0, 64'hFFFF_FFFF_FFFF_FF18, ST_REUSED));
        rows.push_back(row_chk(OP_FREE, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, ST_UNKNOWN));
        rows.push_back(row_cfg(64'd0, 32'd1000));
        rows.push_back(row_chk(OP_ALLOC, 64'd294, 64'd0, ST_NO_SPACE));
        rows.push_back(row_chk(OP_ALLOC, 64'd293, 64'd707, ST_APPENDED));
        rows.push_back(row_chk(OP_ALLOC, 64'd0, 64'd0, ST_NO_SPACE));
        rows.push_back(row_chk(OP_FREE, 64'd707, 64'd0, ST_FREED));
        rows.push_back(row_chk(OP_ALLOC, 64'd293, 64'd707, ST_REUSED));

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[k]) begin
            if (rows[k].kind == ROW_CFG) begin
                wait_idle();
                set_heap(rows[k].val, rows[k].bytes);
            end else begin
                req.op                = rows[k].op;
                req.amount_or_address = rows[k].val;
                send_request(req, rows[k].has_want, rows[k].want);
            end
        end

        for (int ph = 0; ph < 4; ph++) begin
            wait_idle();
            case (ph)
                0: begin
                    set_heap({$urandom, $urandom}, 32'hFFFF_FFFF);
                    alloc_pct = 75;
                end
                1: begin
                    room = bump_off + 64'd400;
                    set_heap(64'd0, (room > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : room[31:0]);
                    alloc_pct = 60;
                end
                2: begin
                    set_heap(64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
                    alloc_pct = 50;
                end
                default: begin
                    set_heap({$urandom, $urandom}, 32'hFFFF_FFFF);
                    alloc_pct = 85;
                end
            endcase
            for (int n = 0; n < 95; n++) begin
                if ($urandom_range(0, 49) == 0) begin
                    wait_idle();
                end
                send_request(random_request(alloc_pct, ph == 1 || ph == 2), 1'b0, '0);
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
